>>> rtl/occupation_pair_classifier_top_macros.svh
// assertion macros for the occupation pair classifier
// used by occupation_pair_classifier_top; no other dependencies
`ifndef OCCUPATION_PAIR_CLASSIFIER_TOP_MACROS_SVH
`define OCCUPATION_PAIR_CLASSIFIER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, disabled in reset
`define OPC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// next-cycle implication, disabled in reset
`define OPC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define OPC_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define OPC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/opc_pkg.sv
// shared types and constants of the occupation pair classifier
// no dependencies
`default_nettype none

package opc_pkg;

    // fixed field widths
    localparam int WORD_W      = 32;
    localparam int INDEX_W     = 10;
    localparam int CFG_W       = 4;
    localparam int ORDER_W     = 24;
    localparam int SLOT_W      = 3;
    localparam int ORDER_SLOTS = ORDER_W / SLOT_W;
    localparam int DIFF_W      = 3;
    localparam int CNT_W       = 3;
    localparam int CODE_W      = 3;
    localparam int TAG_W       = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // qualification limits and tag scale
    localparam int COUNT_LIMIT = 5;
    localparam int PEAK_LIMIT  = 3;
    localparam int TAG_SCALE   = 10;

    typedef logic signed [DIFF_W-1:0] diff_t;

    // marks a slot outside the orbitals in use; below every real diff
    localparam diff_t DIFF_EMPTY = 3'sb100;

    // recorded tags
    localparam logic signed [TAG_W-1:0] TAG_EQUAL = 7'sd0;
    localparam logic signed [TAG_W-1:0] TAG_21    = 7'sd21;
    localparam logic signed [TAG_W-1:0] TAG_22    = 7'sd22;
    localparam logic signed [TAG_W-1:0] TAG_32    = 7'sd32;
    localparam logic signed [TAG_W-1:0] TAG_41    = 7'sd41;

    // case codes
    localparam logic [CODE_W-1:0] CASE_EQUAL = 3'd0;
    localparam logic [CODE_W-1:0] CASE_TAG21 = 3'd1;
    localparam logic [CODE_W-1:0] CASE_TAG22 = 3'd2;
    localparam logic [CODE_W-1:0] CASE_TAG32 = 3'd3;
    localparam logic [CODE_W-1:0] CASE_TAG41 = 3'd4;

    // per-stage control travelling down the cell chain
    typedef struct packed {
        logic               valid;
        logic               keep;
        logic [CNT_W-1:0]   count;
        logic [INDEX_W-1:0] ket_index;
        logic [INDEX_W-1:0] bra_index;
    } stage_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/opc_ifs.sv
// valid/ready channel interfaces: pair input, record output, configuration
// depends on opc_pkg
`default_nettype none

interface opc_in_if;
    logic                         valid;
    logic                         ready;
    logic [opc_pkg::WORD_W-1:0]   ket_occupations;
    logic [opc_pkg::WORD_W-1:0]   bra_occupations;
    logic [opc_pkg::INDEX_W-1:0]  ket_index;
    logic [opc_pkg::INDEX_W-1:0]  bra_index;

    modport source (output valid, ket_occupations, bra_occupations, ket_index, bra_index,
                    input ready);
    modport sink (input valid, ket_occupations, bra_occupations, ket_index, bra_index,
                  output ready);
endinterface

interface opc_out_if;
    logic                         valid;
    logic                         ready;
    logic [opc_pkg::CODE_W-1:0]   case_code;
    logic [opc_pkg::INDEX_W-1:0]  ket_label;
    logic [opc_pkg::INDEX_W-1:0]  bra_label;
    logic [opc_pkg::ORDER_W-1:0]  orbital_order;

    modport source (output valid, case_code, ket_label, bra_label, orbital_order,
                    input ready);
    modport sink (input valid, case_code, ket_label, bra_label, orbital_order,
                  output ready);
endinterface

interface opc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [opc_pkg::CFG_W-1:0]  orbitals_in_use;

    modport source (output valid, orbitals_in_use, input ready);
    modport sink (input valid, orbitals_in_use, output ready);
endinterface

`default_nettype wire

>>> rtl/opc_front.sv
// front cell: unpacks occupations, forms diffs, counts and qualifies a pair
// depends on opc_pkg and opc_ifs
`default_nettype none

module opc_front #(
    parameter int MAX_ORBITALS = 8,
    parameter int OCC_BITS     = 4,
    localparam int ORD_W       = $clog2(MAX_ORBITALS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    opc_in_if.sink                      pair_in,
    input  logic [opc_pkg::CFG_W-1:0]   orbitals_in_use,
    input  logic                        down_adv,
    output opc_pkg::stage_ctrl_t        ctrl,
    output opc_pkg::diff_t              diff [MAX_ORBITALS],
    output logic [ORD_W-1:0]            ord [MAX_ORBITALS]
);

    localparam int DW = OCC_BITS + 1;
    localparam int CW = $clog2(MAX_ORBITALS + 1);

    logic [OCC_BITS-1:0]        ket_o [MAX_ORBITALS];
    logic [OCC_BITS-1:0]        bra_o [MAX_ORBITALS];
    logic signed [DW-1:0]       diff_w [MAX_ORBITALS];
    opc_pkg::diff_t             diff_next [MAX_ORBITALS];
    logic [MAX_ORBITALS-1:0]    nz;
    logic [MAX_ORBITALS-1:0]    big;
    logic [CW-1:0]              cnt;
    logic                       keep;
    logic                       adv;

    logic                       valid_reg;
    logic                       keep_reg;
    logic [opc_pkg::CNT_W-1:0]  count_reg;
    logic [opc_pkg::INDEX_W-1:0] ket_idx_reg;
    logic [opc_pkg::INDEX_W-1:0] bra_idx_reg;
    opc_pkg::diff_t             diff_reg [MAX_ORBITALS];

    // per-orbital unpack and difference; slots past the word read as zero
    genvar g, b;
    generate
        for (g = 0; g < MAX_ORBITALS; g++)
        begin : g_orb
            for (b = 0; b < OCC_BITS; b++)
            begin : g_bit
                if (g * OCC_BITS + b < opc_pkg::WORD_W)
                begin : g_in
                    assign ket_o[g][b] = pair_in.ket_occupations[g * OCC_BITS + b];
                    assign bra_o[g][b] = pair_in.bra_occupations[g * OCC_BITS + b];
                end
                else
                begin : g_out
                    assign ket_o[g][b] = 1'b0;
                    assign bra_o[g][b] = 1'b0;
                end
            end

            logic active;
            assign active    = g < int'(orbitals_in_use);
            assign diff_w[g] = $signed({1'b0, bra_o[g]}) - $signed({1'b0, ket_o[g]});
            assign nz[g]     = active && (diff_w[g] != '0);
            assign big[g]    = active && ((diff_w[g] >= DW'(opc_pkg::PEAK_LIMIT)) ||
                                          (diff_w[g] <= -DW'(opc_pkg::PEAK_LIMIT)));
            assign diff_next[g] = active ? opc_pkg::DIFF_W'(diff_w[g]) : opc_pkg::DIFF_EMPTY;
            assign ord[g]       = ORD_W'(g);
        end
    endgenerate

    // nonzero count and qualification
    always_comb
    begin
        cnt = '0;
        for (int i = 0; i < MAX_ORBITALS; i++)
        begin
            cnt = cnt + CW'(nz[i]);
        end
        keep = (int'(cnt) < opc_pkg::COUNT_LIMIT) && !(|big);
    end

    // stage handshake
    assign adv           = !valid_reg || down_adv;
    assign pair_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= pair_in.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv && pair_in.valid)
        begin
            keep_reg    <= keep;
            count_reg   <= opc_pkg::CNT_W'(cnt);
            ket_idx_reg <= pair_in.ket_index;
            bra_idx_reg <= pair_in.bra_index;
            diff_reg    <= diff_next;
        end
    end

    assign ctrl = '{valid: valid_reg, keep: keep_reg, count: count_reg,
                    ket_index: ket_idx_reg, bra_index: bra_idx_reg};
    assign diff = diff_reg;

endmodule

`default_nettype wire

>>> rtl/opc_sort_cell.sv
// sort cell: one pass of the exchange sort, slot PASS against all later slots
// depends on opc_pkg
`default_nettype none

module opc_sort_cell #(
    parameter int MAX_ORBITALS = 8,
    parameter int PASS         = 0,
    localparam int ORD_W       = $clog2(MAX_ORBITALS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  opc_pkg::stage_ctrl_t    ctrl_in,
    input  opc_pkg::diff_t          diff_in [MAX_ORBITALS],
    input  logic [ORD_W-1:0]        ord_in [MAX_ORBITALS],
    input  logic                    down_adv,
    output logic                    up_adv,
    output opc_pkg::stage_ctrl_t    ctrl_out,
    output opc_pkg::diff_t          diff_out [MAX_ORBITALS],
    output logic [ORD_W-1:0]        ord_out [MAX_ORBITALS]
);

    opc_pkg::diff_t         d_x [MAX_ORBITALS];
    logic [ORD_W-1:0]       o_x [MAX_ORBITALS];
    logic                   adv;

    logic                   valid_reg;
    opc_pkg::stage_ctrl_t   ctrl_reg;
    opc_pkg::diff_t         diff_reg [MAX_ORBITALS];
    logic [ORD_W-1:0]       ord_reg [MAX_ORBITALS];

    // exchange pass: later slot swaps in when strictly larger
    always_comb
    begin
        opc_pkg::diff_t   t;
        logic [ORD_W-1:0] ot;
        t   = '0;
        ot  = '0;
        d_x = diff_in;
        o_x = ord_in;
        for (int j = 0; j < MAX_ORBITALS; j++)
        begin
            if (j > PASS)
            begin
                if (d_x[j] > d_x[PASS])
                begin
                    t         = d_x[PASS];
                    d_x[PASS] = d_x[j];
                    d_x[j]    = t;
                    ot        = o_x[PASS];
                    o_x[PASS] = o_x[j];
                    o_x[j]    = ot;
                end
            end
        end
    end

    // stage handshake
    assign adv    = !valid_reg || down_adv;
    assign up_adv = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= ctrl_in.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv && ctrl_in.valid)
        begin
            ctrl_reg <= ctrl_in;
            diff_reg <= d_x;
            ord_reg  <= o_x;
        end
    end

    always_comb
    begin
        ctrl_out       = ctrl_reg;
        ctrl_out.valid = valid_reg;
    end

    assign diff_out = diff_reg;
    assign ord_out  = ord_reg;

endmodule

`default_nettype wire

>>> rtl/opc_back.sv
// back cell: tag decode, orbital order packing and output register
// depends on opc_pkg and opc_ifs
`default_nettype none

module opc_back #(
    parameter int MAX_ORBITALS = 8,
    localparam int ORD_W       = $clog2(MAX_ORBITALS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  opc_pkg::stage_ctrl_t    ctrl_in,
    input  opc_pkg::diff_t          diff_in [MAX_ORBITALS],
    input  logic [ORD_W-1:0]        ord_in [MAX_ORBITALS],
    output logic                    up_adv,
    opc_out_if.source               rec_out
);

    localparam int PACK_SLOTS = (MAX_ORBITALS < opc_pkg::ORDER_SLOTS) ?
                                MAX_ORBITALS : opc_pkg::ORDER_SLOTS;

    opc_pkg::diff_t                     top;
    logic signed [opc_pkg::TAG_W-1:0]   scaled;
    logic signed [opc_pkg::TAG_W-1:0]   tag;
    logic                               match;
    logic [opc_pkg::CODE_W-1:0]         code;
    logic [opc_pkg::ORDER_W-1:0]        order;
    logic                               hit;
    logic                               adv;

    logic                               out_valid_reg;
    logic [opc_pkg::CODE_W-1:0]         code_reg;
    logic [opc_pkg::INDEX_W-1:0]        ket_label_reg;
    logic [opc_pkg::INDEX_W-1:0]        bra_label_reg;
    logic [opc_pkg::ORDER_W-1:0]        order_reg;

    // tag = 10 * count + first sorted diff (zero when no orbital in use)
    always_comb
    begin
        top    = (diff_in[0] == opc_pkg::DIFF_EMPTY) ? '0 : diff_in[0];
        scaled = $signed(opc_pkg::TAG_W'(ctrl_in.count) * opc_pkg::TAG_W'(opc_pkg::TAG_SCALE));
        tag    = scaled + opc_pkg::TAG_W'(top);
    end

    // recorded tags
    always_comb
    begin
        match = 1'b1;
        code  = opc_pkg::CASE_EQUAL;
        unique case (tag)
            opc_pkg::TAG_EQUAL: code = opc_pkg::CASE_EQUAL;
            opc_pkg::TAG_21:    code = opc_pkg::CASE_TAG21;
            opc_pkg::TAG_22:    code = opc_pkg::CASE_TAG22;
            opc_pkg::TAG_32:    code = opc_pkg::CASE_TAG32;
            opc_pkg::TAG_41:    code = opc_pkg::CASE_TAG41;
            default:            match = 1'b0;
        endcase
    end

    // orbital order, slots outside the orbitals in use stay zero
    always_comb
    begin
        order = '0;
        for (int s = 0; s < PACK_SLOTS; s++)
        begin
            if (diff_in[s] != opc_pkg::DIFF_EMPTY)
            begin
                order[s * opc_pkg::SLOT_W +: opc_pkg::SLOT_W] = opc_pkg::SLOT_W'(ord_in[s]);
            end
        end
    end

    assign hit    = ctrl_in.valid && ctrl_in.keep && match;
    assign adv    = !out_valid_reg || rec_out.ready;
    assign up_adv = adv;

    // output valid; items with no record drop out here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= hit;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (adv && hit)
        begin
            code_reg      <= code;
            ket_label_reg <= ctrl_in.ket_index;
            bra_label_reg <= ctrl_in.bra_index;
            order_reg     <= order;
        end
    end

    assign rec_out.valid         = out_valid_reg;
    assign rec_out.case_code     = code_reg;
    assign rec_out.ket_label     = ket_label_reg;
    assign rec_out.bra_label     = bra_label_reg;
    assign rec_out.orbital_order = order_reg;

endmodule

`default_nettype wire

>>> rtl/occupation_pair_classifier_top.sv
// top level of the occupation pair classifier: front cell, sort cell chain, back cell
// depends on opc_pkg, opc_ifs, opc_front, opc_sort_cell, opc_back and the macro header
`default_nettype none

`include "occupation_pair_classifier_top_macros.svh"

// Classifies a ket/bra occupation pair. One pair is accepted every clock cycle
// unless a record held at the output has filled every cell; a record leaves
// through MAX_ORBITALS + 1 registers (front cell, loaded at the accepting edge,
// MAX_ORBITALS - 1 sort cells each doing one exchange pass, output register),
// and pairs that give no record simply leave no item. The chain collapses
// bubbles, so while a record waits at the output the pair input stays open
// until every cell is full. orbitals_in_use is sampled when a pair enters the
// front cell; the configuration channel is always ready.
module occupation_pair_classifier_top #(
    parameter int MAX_ORBITALS = 8,
    parameter int OCC_BITS     = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    opc_cfg_if.sink     cfg,
    opc_in_if.sink      pair_in,
    opc_out_if.source   rec_out
);

    localparam int N     = MAX_ORBITALS;
    localparam int ORD_W = $clog2(MAX_ORBITALS);

    logic [opc_pkg::CFG_W-1:0]  orbitals_in_use_reg;

    opc_pkg::stage_ctrl_t       ctrl_ch [N];
    opc_pkg::diff_t             diff_ch [N][N];
    logic [ORD_W-1:0]           ord_ch  [N][N];
    logic [N:1]                 adv_ch;

    // configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orbitals_in_use_reg <= opc_pkg::CFG_RESET;
        end
        else if (cfg.valid)
        begin
            orbitals_in_use_reg <= cfg.orbitals_in_use;
        end
    end

    // front cell
    opc_front #(
        .MAX_ORBITALS (N),
        .OCC_BITS     (OCC_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .pair_in         (pair_in),
        .orbitals_in_use (orbitals_in_use_reg),
        .down_adv        (adv_ch[1]),
        .ctrl            (ctrl_ch[0]),
        .diff            (diff_ch[0]),
        .ord             (ord_ch[0])
    );

    // chain of sort cells, one exchange pass each
    genvar k;
    generate
        for (k = 1; k < N; k++)
        begin : g_cell
            opc_sort_cell #(
                .MAX_ORBITALS (N),
                .PASS         (k - 1)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl_in  (ctrl_ch[k-1]),
                .diff_in  (diff_ch[k-1]),
                .ord_in   (ord_ch[k-1]),
                .down_adv (adv_ch[k+1]),
                .up_adv   (adv_ch[k]),
                .ctrl_out (ctrl_ch[k]),
                .diff_out (diff_ch[k]),
                .ord_out  (ord_ch[k])
            );
        end
    endgenerate

    // back cell and output register
    opc_back #(
        .MAX_ORBITALS (N)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl_in (ctrl_ch[N-1]),
        .diff_in (diff_ch[N-1]),
        .ord_in  (ord_ch[N-1]),
        .up_adv  (adv_ch[N]),
        .rec_out (rec_out)
    );

    // checks
    `OPC_ASSERT_NEXT(a_accept_fills_front, clk, rst_n, pair_in.valid && pair_in.ready, ctrl_ch[0].valid)
    `OPC_ASSERT_IMPL(a_empty_output_opens_input, clk, rst_n, !rec_out.valid, pair_in.ready)
    `OPC_ASSERT_IMPL(a_code_in_range, clk, rst_n, rec_out.valid, rec_out.case_code <= opc_pkg::CASE_TAG41)

endmodule

`default_nettype wire
